[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication to the next cycle, off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Implication to the next cycle, checked during reset as well.
`define ASSERT_NEXT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/wvh_pkg.sv]
// Package for the weighted velocity histogram: types, codes and defaults.
`default_nettype none
package wvh_pkg;

    localparam int DIMENSIONS_DEF    = 3;
    localparam int BINS_DEF          = 128;
    localparam int SPECIES_COUNT_DEF = 4;
    localparam int PROBE_COUNT_DEF   = 4;

    localparam int FIFO_DEPTH = 4;
    localparam int VEL_W      = 32;
    localparam int WEIGHT_W   = 32;
    localparam int ACC_W      = 48;
    localparam int S_DATA_W   = 144;
    localparam int S_USER_W   = 2;
    localparam int PADDR_W    = 5;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    localparam logic [31:0] RST_V_MIN     = 32'hFFFC_1800;
    localparam logic [31:0] RST_INV_V     = 32'd790920;
    localparam logic [31:0] RST_INV_SPEED = 32'd1174471;
    localparam logic [31:0] RST_INV_SQ    = 32'd1174;
    localparam logic [7:0]  RST_BINS      = 8'd99;

    localparam logic [2:0] REG_V_MIN     = 3'd0;
    localparam logic [2:0] REG_INV_V     = 3'd1;
    localparam logic [2:0] REG_INV_SPEED = 3'd2;
    localparam logic [2:0] REG_INV_SQ    = 3'd3;
    localparam logic [2:0] REG_BINS      = 3'd4;

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_RCLR   = 2'd2;

    typedef enum logic [1:0] {
        OP_ACC,
        OP_READ,
        OP_RCLR,
        OP_ZERO
    } t_op_kind;

    typedef struct packed {
        logic [31:0] v_min;
        logic [31:0] inv_v;
        logic [31:0] inv_speed;
        logic [31:0] inv_sq;
        logic [7:0]  bins_in_use;
    } t_cfg;

endpackage
`default_nettype wire

[hdl/wvh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wvh_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[hdl/wvh_fifo.sv]
// Small register queue between the front and back parts.
`default_nettype none
module wvh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

[hdl/wvh_front.sv]
// Front part: accept words, compute bins, queue store operations.
`default_nettype none
module wvh_front #(
    parameter int DIMENSIONS    = 3,
    parameter int BINS          = 128,
    parameter int SPECIES_COUNT = 4,
    parameter int PROBE_COUNT   = 4,
    parameter int ADDR_W        = 14
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire wvh_pkg::t_cfg                 i_cfg,
    input  wire logic                          i_hold,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [wvh_pkg::S_DATA_W-1:0]  i_data,
    input  wire logic [wvh_pkg::S_USER_W-1:0]  i_user,
    output logic                               o_push,
    output logic [ADDR_W+wvh_pkg::WEIGHT_W+1:0] o_op,
    input  wire logic                          i_full
);
    import wvh_pkg::*;

    localparam int VAR_COUNT = DIMENSIONS + 2;
    localparam int LIM_W     = 12;

    typedef enum logic [3:0] {
        F_IDLE, F_RPUSH, F_DMUL, F_DSQ, F_SQRT, F_SMUL, F_HMUL, F_LMUL, F_PUSH
    } t_fstate;

    t_fstate       r_state;
    logic [1:0]    r_mode;
    logic [1:0]    r_probe;
    logic [1:0]    r_species;
    logic [31:0]   r_vel [3];
    logic [31:0]   r_weight;
    logic [2:0]    r_var;
    logic [6:0]    r_bin;
    logic          r_neg;
    logic [63:0]   r_prod;
    logic [63:0]   r_hi;
    logic [63:0]   r_sq;
    logic [63:0]   r_x;
    logic [63:0]   r_r;
    logic [63:0]   r_b;
    logic [4:0]    r_cnt;

    logic [31:0]   vel_cur;
    logic [32:0]   diff;
    logic [31:0]   diff_mag;
    logic [31:0]   vel_mag;
    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   mul_p;
    logic [63:0]   mid;
    logic [63:0]   q;
    logic          sign_ok;
    logic [LIM_W-1:0] limit;
    logic          keep;
    logic          rd_ok;
    t_op_kind      kind;
    logic [LIM_W-1:0] bin_sel;
    logic [ADDR_W-1:0] addr;
    logic [63:0]   sq_t;
    logic          accept;

    always_comb begin
        case (r_var)
            3'd0:    vel_cur = r_vel[0];
            3'd1:    vel_cur = r_vel[1];
            default: vel_cur = r_vel[2];
        endcase
    end

    assign diff     = {vel_cur[31], vel_cur} - {i_cfg.v_min[31], i_cfg.v_min};
    assign diff_mag = diff[32] ? 32'(-diff) : diff[31:0];
    assign vel_mag  = vel_cur[31] ? (~vel_cur + 32'd1) : vel_cur;

    // one shared multiplier, operands picked by state
    always_comb begin
        case (r_state)
            F_DMUL:  begin mul_a = diff_mag;     mul_b = i_cfg.inv_v;     end
            F_DSQ:   begin mul_a = vel_mag;      mul_b = vel_mag;         end
            F_SMUL:  begin mul_a = r_r[31:0];    mul_b = i_cfg.inv_speed; end
            F_HMUL:  begin mul_a = r_sq[63:32];  mul_b = i_cfg.inv_sq;    end
            default: begin mul_a = r_sq[31:0];   mul_b = i_cfg.inv_sq;    end
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign mid = r_hi + {32'd0, r_prod[63:32]};

    always_comb begin
        if (32'(r_var) < DIMENSIONS) begin
            q       = {32'd0, r_prod[63:32]};
            sign_ok = !r_neg || (r_prod[63:32] == '0);
        end else if (32'(r_var) == DIMENSIONS) begin
            q       = {32'd0, r_prod[63:32]};
            sign_ok = 1'b1;
        end else begin
            q       = {8'd0, mid[63:8]};
            sign_ok = 1'b1;
        end
    end

    assign limit = (LIM_W'(i_cfg.bins_in_use) > LIM_W'(BINS)) ? LIM_W'(BINS)
                                                              : LIM_W'(i_cfg.bins_in_use);
    assign keep  = sign_ok && (q[63:LIM_W] == '0) && (q[LIM_W-1:0] < limit);

    assign rd_ok = (32'(r_probe) < PROBE_COUNT) && (32'(r_species) < SPECIES_COUNT)
                && (32'(r_var) < VAR_COUNT) && (32'(r_bin) < BINS);

    always_comb begin
        if (r_state == F_RPUSH) begin
            bin_sel = LIM_W'(r_bin);
            if (!rd_ok) begin
                kind = OP_ZERO;
            end else if (r_mode == MODE_RCLR) begin
                kind = OP_RCLR;
            end else begin
                kind = OP_READ;
            end
        end else begin
            bin_sel = q[LIM_W-1:0];
            kind    = OP_ACC;
        end
    end

    assign addr = (((ADDR_W'(r_probe) * ADDR_W'(SPECIES_COUNT) + ADDR_W'(r_species))
                   * ADDR_W'(VAR_COUNT) + ADDR_W'(r_var)) * ADDR_W'(BINS))
                  + ADDR_W'(bin_sel);

    assign o_op   = {kind, (kind == OP_ZERO) ? {ADDR_W{1'b0}} : addr, r_weight};
    assign o_push = !i_full && ((r_state == F_RPUSH) || ((r_state == F_PUSH) && keep));

    assign o_ready = (r_state == F_IDLE) && !i_hold;
    assign accept  = i_valid && o_ready;

    assign sq_t = r_r + r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_mode    <= i_user;
                        r_probe   <= i_data[1:0];
                        r_species <= i_data[3:2];
                        r_vel[0]  <= i_data[35:4];
                        r_vel[1]  <= i_data[67:36];
                        r_vel[2]  <= i_data[99:68];
                        r_weight  <= i_data[131:100];
                        r_bin     <= i_data[141:135];
                        r_sq      <= '0;
                        case (i_user)
                            MODE_SAMPLE: begin
                                r_var <= 3'd0;
                                if ((32'(i_data[1:0]) < PROBE_COUNT)
                                    && (32'(i_data[3:2]) < SPECIES_COUNT)) begin
                                    r_state <= F_DMUL;
                                end
                            end
                            MODE_READ, MODE_RCLR: begin
                                r_var   <= i_data[134:132];
                                r_state <= F_RPUSH;
                            end
                            default: r_state <= F_IDLE;
                        endcase
                    end
                end
                F_RPUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                F_DMUL: begin
                    r_prod  <= mul_p;
                    r_neg   <= diff[32];
                    r_state <= F_PUSH;
                end
                F_DSQ: begin
                    r_sq <= r_sq + mul_p;
                    if (32'(r_var) == DIMENSIONS - 1) begin
                        r_var   <= 3'(DIMENSIONS);
                        r_x     <= r_sq + mul_p;
                        r_r     <= '0;
                        r_b     <= 64'd1 << 62;
                        r_cnt   <= '0;
                        r_state <= F_SQRT;
                    end else begin
                        r_var   <= r_var + 3'd1;
                        r_state <= F_DMUL;
                    end
                end
                F_SQRT: begin
                    // one result bit per cycle
                    if (r_x >= sq_t) begin
                        r_x <= r_x - sq_t;
                        r_r <= (r_r >> 1) + r_b;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_b   <= r_b >> 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= F_SMUL;
                    end
                end
                F_SMUL: begin
                    r_prod  <= mul_p;
                    r_state <= F_PUSH;
                end
                F_HMUL: begin
                    r_prod  <= mul_p;
                    r_var   <= 3'(DIMENSIONS + 1);
                    r_state <= F_LMUL;
                end
                F_LMUL: begin
                    r_hi    <= r_prod;
                    r_prod  <= mul_p;
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    // hold while the queue is full and this bin is kept
                    if (!keep || !i_full) begin
                        if (32'(r_var) < DIMENSIONS) begin
                            r_state <= F_DSQ;
                        end else if (32'(r_var) == DIMENSIONS) begin
                            r_state <= F_HMUL;
                        end else begin
                            r_state <= F_IDLE;
                        end
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[hdl/wvh_back.sv]
// Back part: clear the store, then run read-modify-write operations.
`default_nettype none
module wvh_back #(
    parameter int DEPTH  = 10240,
    parameter int ADDR_W = 14
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_empty,
    input  wire logic [ADDR_W+wvh_pkg::WEIGHT_W+1:0] i_op,
    output logic                                  o_pop,
    output logic                                  o_clearing,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic      [wvh_pkg::ACC_W-1:0]        o_data
);
    import wvh_pkg::*;

    typedef enum logic [1:0] {
        B_CLEAR, B_RUN, B_WAIT
    } t_bstate;

    t_bstate            r_state;
    logic [ADDR_W-1:0]  r_clr;
    t_op_kind           r_kind;
    logic [ADDR_W-1:0]  r_addr;
    logic [WEIGHT_W-1:0] r_weight;
    logic               r_valid;
    logic [ACC_W-1:0]   r_data;

    t_op_kind           q_kind;
    logic [ADDR_W-1:0]  q_addr;
    logic [WEIGHT_W-1:0] q_weight;
    logic [ACC_W-1:0]   rdata;
    logic [ACC_W:0]     sum;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ACC_W-1:0]   wdata;

    assign q_kind   = t_op_kind'(i_op[ADDR_W+WEIGHT_W+1 -: 2]);
    assign q_addr   = i_op[ADDR_W+WEIGHT_W-1 -: ADDR_W];
    assign q_weight = i_op[WEIGHT_W-1:0];

    // reads wait for a free output register, accumulates never do
    assign o_pop = (r_state == B_RUN) && !i_empty && ((q_kind == OP_ACC) || !r_valid);

    assign sum = {1'b0, rdata} + (ACC_W+1)'(r_weight);

    always_comb begin
        we    = 1'b0;
        waddr = r_addr;
        wdata = '0;
        if (r_state == B_CLEAR) begin
            we    = 1'b1;
            waddr = r_clr;
        end else if (r_state == B_WAIT) begin
            if (r_kind == OP_ACC) begin
                we    = 1'b1;
                wdata = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
            end else if (r_kind == OP_RCLR) begin
                we    = 1'b1;
            end
        end
    end

    wvh_ram #(
        .WIDTH (ACC_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (o_pop && (q_kind != OP_ZERO)),
        .i_raddr (q_addr),
        .o_rdata (rdata)
    );

    assign o_clearing = (r_state == B_CLEAR);
    assign o_valid    = r_valid;
    assign o_data     = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= B_RUN;
                    end
                end
                B_RUN: begin
                    if (o_pop) begin
                        r_kind   <= q_kind;
                        r_addr   <= q_addr;
                        r_weight <= q_weight;
                        if (q_kind == OP_ZERO) begin
                            r_valid <= 1'b1;
                            r_data  <= '0;
                        end else begin
                            r_state <= B_WAIT;
                        end
                    end
                end
                B_WAIT: begin
                    if (r_kind != OP_ACC) begin
                        r_valid <= 1'b1;
                        r_data  <= rdata;
                    end
                    r_state <= B_RUN;
                end
                default: r_state <= B_RUN;
            endcase
        end
    end
endmodule
`default_nettype wire

[hdl/weighted_velocity_histogram.sv]
// Top level of the weighted velocity histogram.
//
//  channel  dir  handshake                 content
//  s_*      in   s_tvalid / s_tready       sample, read or read-and-clear word
//  m_*      out  m_tvalid / m_tready       48-bit bin total of a read
//  apb      in   psel & penable & pwrite   five configuration registers
//
// A sample word runs in the front part as one multiply per step on a shared
// 32x32 multiplier and a shift-and-subtract square root.
// A read word leaves the front part from its push state; the back part runs each
// store operation as a registered RAM read, then a write back where the operation
// needs one, before it takes the next. After reset the store is cleared, one entry
// a cycle: PROBE_COUNT*SPECIES_COUNT*(DIMENSIONS+2)*BINS entries (10240 by default), with s_tready low.
// Either side may stall; the queue and the output register decouple them.
`default_nettype none
module weighted_velocity_histogram #(
    parameter int DIMENSIONS    = wvh_pkg::DIMENSIONS_DEF,
    parameter int BINS          = wvh_pkg::BINS_DEF,
    parameter int SPECIES_COUNT = wvh_pkg::SPECIES_COUNT_DEF,
    parameter int PROBE_COUNT   = wvh_pkg::PROBE_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // probe[1:0] species[3:2] vel_x[35:4] vel_y[67:36] vel_z[99:68]
    // weight[131:100] variable[134:132] bin[141:135], zero pad above
    input  wire logic [wvh_pkg::S_DATA_W-1:0]  s_tdata,
    // mode[1:0]
    input  wire logic [wvh_pkg::S_USER_W-1:0]  s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // bin_total[47:0]
    output logic      [wvh_pkg::ACC_W-1:0]     m_tdata,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [wvh_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);
    import wvh_pkg::*;

    localparam int VAR_COUNT = DIMENSIONS + 2;
    localparam int DEPTH     = PROBE_COUNT * SPECIES_COUNT * VAR_COUNT * BINS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int OP_W      = ADDR_W + WEIGHT_W + 2;

    t_cfg            r_cfg;
    logic [2:0]      reg_idx;
    logic            front_ready;
    logic            clearing;
    logic            push;
    logic [OP_W-1:0] op_in;
    logic [OP_W-1:0] op_out;
    logic            full;
    logic            empty;
    logic            pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    // register writes land on the access phase; unknown addresses drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.v_min       <= RST_V_MIN;
            r_cfg.inv_v       <= RST_INV_V;
            r_cfg.inv_speed   <= RST_INV_SPEED;
            r_cfg.inv_sq      <= RST_INV_SQ;
            r_cfg.bins_in_use <= RST_BINS;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_V_MIN:     r_cfg.v_min       <= pwdata;
                REG_INV_V:     r_cfg.inv_v       <= pwdata;
                REG_INV_SPEED: r_cfg.inv_speed   <= pwdata;
                REG_INV_SQ:    r_cfg.inv_sq      <= pwdata;
                REG_BINS:      r_cfg.bins_in_use <= pwdata[7:0];
                default:       r_cfg             <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_V_MIN:     prdata = r_cfg.v_min;
            REG_INV_V:     prdata = r_cfg.inv_v;
            REG_INV_SPEED: prdata = r_cfg.inv_speed;
            REG_INV_SQ:    prdata = r_cfg.inv_sq;
            REG_BINS:      prdata = {24'd0, r_cfg.bins_in_use};
            default:       prdata = '0;
        endcase
    end

    // hold input off while the store is swept after reset
    assign s_tready = front_ready && !clearing;

    wvh_front #(
        .DIMENSIONS    (DIMENSIONS),
        .BINS          (BINS),
        .SPECIES_COUNT (SPECIES_COUNT),
        .PROBE_COUNT   (PROBE_COUNT),
        .ADDR_W        (ADDR_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_hold  (clearing),
        .i_valid (s_tvalid),
        .o_ready (front_ready),
        .i_data  (s_tdata),
        .i_user  (s_tuser),
        .o_push  (push),
        .o_op    (op_in),
        .i_full  (full)
    );

    wvh_fifo #(
        .WIDTH (OP_W),
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (op_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (op_out),
        .o_empty (empty)
    );

    wvh_back #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_op       (op_out),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_valid    (m_tvalid),
        .i_ready    (m_tready),
        .o_data     (m_tdata)
    );
endmodule
`default_nettype wire

[hdl/wvh_checker.sv]
// Port-level checks for the weighted velocity histogram, bound to the top.
`default_nettype none
`include "assert_macros.svh"
module wvh_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      s_tready,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [wvh_pkg::ACC_W-1:0] m_tdata
);
    // a stalled result word holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // reset starts the clearing sweep, so no word is taken right after
    `ASSERT_NEXT_RST(a_rst_no_ready, i_clk, !i_rst_n, !s_tready)
    // reset drops any pending result
    `ASSERT_NEXT_RST(a_rst_no_out, i_clk, !i_rst_n, !m_tvalid)
endmodule

bind weighted_velocity_histogram wvh_checker u_checker (.*);
`default_nettype wire

[tb/tb_weighted_velocity_histogram.sv]
// Self-checking testbench for the weighted velocity histogram block.
`timescale 1ns / 100ps
`default_nettype none
module tb_weighted_velocity_histogram;
    import wvh_pkg::*;

    // One input word as the block sees it.
    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  probe;
        logic [1:0]  species;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [31:0] weight;
        logic [2:0]  variable;
        logic [6:0]  bin;
    } t_word;

    localparam int NUM_VARS   = DIMENSIONS_DEF + 2;
    localparam int STORE_SIZE = PROBE_COUNT_DEF * SPECIES_COUNT_DEF * NUM_VARS * BINS_DEF;
    localparam int DRAIN_WAIT = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;  // probe, species, vel_x/y/z, weight, variable, bin
    logic [S_USER_W-1:0] s_tuser = '0;  // mode
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [ACC_W-1:0] m_tdata;          // bin_total
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    weighted_velocity_histogram DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: shadow store and shadow registers.
    logic [ACC_W-1:0] shadow_hist [STORE_SIZE];
    t_cfg             shadow_cfg;

    t_word            pending_words [$];
    logic [ACC_W-1:0] expected_totals [$];
    int               fail_count = 0;
    int               words_sent = 0;
    bit               idle_enable = 1'b0;
    bit               hold_sink = 1'b0;

    function automatic int hist_index(input int p, input int s, input int v, input int b);
        return ((p * SPECIES_COUNT_DEF + s) * NUM_VARS + v) * BINS_DEF + b;
    endfunction

    function automatic logic [31:0] sqrt_floor(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    // Add weight into one bin when it falls under the active bin count.
    task automatic add_weight(input int p, input int s, input int v, input logic [63:0] b,
                              input logic [31:0] w);
        logic [63:0] limit;
        logic [48:0] sum;
        int k;
        limit = (shadow_cfg.bins_in_use > BINS_DEF) ? BINS_DEF : shadow_cfg.bins_in_use;
        if (b >= limit) return;
        k = hist_index(p, s, v, int'(b));
        sum = {1'b0, shadow_hist[k]} + w;
        shadow_hist[k] = sum[48] ? ACC_MAX : sum[47:0];
    endtask

    // Apply one accepted word to the shadow store; queue the total a read returns.
    task automatic predict_histogram(input t_word w);
        logic signed [63:0] vmn, vel, diff;
        logic [63:0] mag, sqsum, q, hi, lo, mid;
        logic [31:0] spd;
        logic [31:0] comps [3];
        int k;
        comps[0] = w.vel_x;
        comps[1] = w.vel_y;
        comps[2] = w.vel_z;
        if (w.mode == MODE_SAMPLE) begin
            vmn = {{32{shadow_cfg.v_min[31]}}, shadow_cfg.v_min};
            sqsum = 0;
            for (int d = 0; d < DIMENSIONS_DEF; d++) begin
                vel = {{32{comps[d][31]}}, comps[d]};
                diff = vel - vmn;
                mag = vel < 0 ? -vel : vel;
                sqsum = sqsum + mag * mag;
                mag = diff < 0 ? -diff : diff;
                q = (mag * shadow_cfg.inv_v) >> 32;
                if (diff >= 0 || q == 0) add_weight(w.probe, w.species, d, q, w.weight);
            end
            spd = sqrt_floor(sqsum);
            q = ({32'd0, spd} * shadow_cfg.inv_speed) >> 32;
            add_weight(w.probe, w.species, DIMENSIONS_DEF, q, w.weight);
            hi = (sqsum >> 32) * shadow_cfg.inv_sq;
            lo = sqsum[31:0] * shadow_cfg.inv_sq;
            mid = hi + (lo >> 32);
            add_weight(w.probe, w.species, DIMENSIONS_DEF + 1, mid >> 8, w.weight);
        end else if (w.mode == MODE_READ || w.mode == MODE_RCLR) begin
            if (w.variable < NUM_VARS) begin
                k = hist_index(w.probe, w.species, w.variable, w.bin);
                expected_totals.push_back(shadow_hist[k]);
                if (w.mode == MODE_RCLR) shadow_hist[k] = '0;
            end else begin
                expected_totals.push_back('0);
            end
        end
    endtask

    // Driver: offer queued words, idling at random when enabled.
    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                w = pending_words.pop_front();
                predict_histogram(w);
                words_sent <= words_sent + 1;
            end
            if ((!s_tvalid || s_tready) || 1'b0) begin
                if (pending_words.size() > (s_tvalid && s_tready ? 0 : 0) &&
                    !(idle_enable && $urandom_range(99) < 25)) begin
                    w = pending_words[0];
                    s_tvalid <= 1'b1;
                    s_tuser  <= w.mode;
                    s_tdata  <= {2'b0, w.bin, w.variable, w.weight, w.vel_z, w.vel_y,
                                 w.vel_x, w.species, w.probe};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each bin total against the oldest expectation.
    always @(posedge i_clk) begin
        logic [ACC_W-1:0] want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_totals.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %0h", $realtime, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_totals.pop_front();
                    if (want !== m_tdata) begin
                        $display("%0t: bin_total mismatch, expected %0h, actual %0h",
                                 $realtime, want, m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            m_tready <= !hold_sink && !(idle_enable && $urandom_range(99) < 25);
        end
    end

    // Write one register over APB; shadow it at the access edge.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00}); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_V_MIN:     shadow_cfg.v_min = val;
            REG_INV_V:     shadow_cfg.inv_v = val;
            REG_INV_SPEED: shadow_cfg.inv_speed = val;
            REG_INV_SQ:    shadow_cfg.inv_sq = val;
            default:       shadow_cfg.bins_in_use = val[7:0];
        endcase
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Wait until every queued word is taken and every total has returned.
    task automatic drain_all();
        while (pending_words.size() != 0 || s_tvalid || expected_totals.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic t_word make_sample(input logic [1:0] p, input logic [1:0] s,
                                          input logic [31:0] vx, input logic [31:0] vy,
                                          input logic [31:0] vz, input logic [31:0] w);
        t_word r;
        r = '{MODE_SAMPLE, p, s, vx, vy, vz, w, 3'($urandom), 7'($urandom)};
        return r;
    endfunction

    function automatic t_word make_read(input logic [1:0] m, input logic [1:0] p,
                                        input logic [1:0] s, input logic [2:0] v,
                                        input logic [6:0] b);
        t_word r;
        r = '{m, p, s, $urandom, $urandom, $urandom, $urandom, v, b};
        return r;
    endfunction

    // Velocity near the configured histogram so most samples land in range.
    function automatic logic [31:0] near_velocity();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            default: return 32'($signed($urandom_range(0, 512000)) - 256000);
        endcase
    endfunction

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(7))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'd0;
            default: return $urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    // Random phase: mostly samples, mixed with reads, read-and-clears and unused-mode words.
    task automatic random_phase(input int count);
        t_word w;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5:
                    w = make_sample(2'($urandom), 2'($urandom), near_velocity(),
                                    near_velocity(), near_velocity(), pick_weight());
                6, 7:
                    w = make_read(MODE_READ, 2'($urandom), 2'($urandom),
                                  3'($urandom_range(99) < 90 ? $urandom_range(4) : $urandom),
                                  7'($urandom_range(99) < 70 ? $urandom_range(40, 80)
                                                             : $urandom));
                8:
                    w = make_read(MODE_RCLR, 2'($urandom), 2'($urandom),
                                  3'($urandom_range(4)), 7'($urandom));
                default:
                    w = make_read(2'd3, 2'($urandom), 2'($urandom), 3'($urandom),
                                  7'($urandom));
            endcase
            pending_words.push_back(w);
        end
    endtask

    // Hold the sink off for a long stretch while reads pile up behind it.
    task automatic hold_off_sink();
        hold_sink = 1'b1;
        for (int n = 0; n < 40; n++)
            pending_words.push_back(make_read(MODE_READ, 2'($urandom), 2'($urandom),
                                              3'($urandom_range(4)), 7'($urandom)));
        repeat (300) @(posedge i_clk);
        hold_sink = 1'b0;
    endtask

    initial begin
        for (int k = 0; k < STORE_SIZE; k++) shadow_hist[k] = '0;
        shadow_cfg = '{RST_V_MIN, RST_INV_V, RST_INV_SPEED, RST_INV_SQ, RST_BINS};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, each mode, and the listed corner cases.
        pending_words.push_back(make_sample(0, 0, 32'd0, 32'd0, 32'd0, 32'd65536));
        pending_words.push_back(make_sample(3, 3, 32'h8000_0000, 32'h7FFF_FFFF,
                                            32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_words.push_back(make_sample(1, 2, 32'hFFFC_1700, 32'hFFFC_1800, 32'd1000, 5));
        pending_words.push_back(make_sample(2, 1, 32'd255000, 32'd256000, 32'd0, 7));
        for (int n = 0; n < 4; n++)
            pending_words.push_back(make_sample(3, 3, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                                32'h7FFF_FFFF, 32'hFFFF_FFFF));
        pending_words.push_back(make_read(MODE_READ, 0, 0, 0, 49));
        pending_words.push_back(make_read(MODE_RCLR, 0, 0, 3, 0));
        pending_words.push_back(make_read(MODE_READ, 0, 0, 3, 0));
        pending_words.push_back(make_read(MODE_READ, 3, 3, 4, 127));
        pending_words.push_back(make_read(MODE_READ, 3, 3, 5, 0));
        pending_words.push_back(make_read(MODE_READ, 3, 3, 7, 127));
        pending_words.push_back(make_read(MODE_RCLR, 1, 2, 0, 0));
        pending_words.push_back(make_read(MODE_RCLR, 2, 1, 1, 98));
        pending_words.push_back(make_read(2'd3, 3, 3, 7, 127));
        drain_all();

        idle_enable = 1'b1;
        random_phase(450);
        drain_all();

        // Extremes of the registers: huge bin count, narrow bins, zero bins.
        write_reg(REG_BINS, 8'd255);
        write_reg(REG_V_MIN, 32'h8000_0000);
        write_reg(REG_INV_V, 32'hFFFF_FFFF);
        write_reg(REG_INV_SPEED, 32'd0);
        write_reg(REG_INV_SQ, 32'hFFFF_FFFF);
        hold_off_sink();
        random_phase(400);
        drain_all();

        write_reg(REG_BINS, 8'd0);
        write_reg(REG_V_MIN, 32'h7FFF_FFFF);
        write_reg(REG_INV_V, 32'd0);
        write_reg(REG_INV_SPEED, 32'hFFFF_FFFF);
        write_reg(REG_INV_SQ, 32'd0);
        random_phase(200);
        drain_all();

        write_reg(REG_BINS, 8'd1);
        write_reg(REG_V_MIN, 32'hFFFF_0000);
        write_reg(REG_INV_V, 32'd16_777_216);
        write_reg(REG_INV_SPEED, 32'd65536);
        write_reg(REG_INV_SQ, 32'd40);
        random_phase(200);
        drain_all();

        // Back near reset values, run long without idling, then idle again.
        write_reg(REG_BINS, 8'd128);
        write_reg(REG_V_MIN, RST_V_MIN);
        write_reg(REG_INV_V, RST_INV_V);
        write_reg(REG_INV_SPEED, RST_INV_SPEED);
        write_reg(REG_INV_SQ, RST_INV_SQ);
        idle_enable = 1'b0;
        random_phase(250);
        drain_all();
        idle_enable = 1'b1;
        random_phase(300);
        drain_all();

        if (fail_count == 0 && expected_totals.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog covering the clear pass and the slowest correct run.
    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
